FILE: sv/rled_pkg.sv
// Package for the run-length encoder with decimal counts.
// Holds the shared widths, the closed-run record and the digit helper functions.
// No dependencies.
package rled_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 16;
  localparam int POS_W       = 3;
  localparam int MAX_RUN_DEF = 65535;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

  // A closed run waiting to be written out as symbol plus decimal digits.
  typedef struct packed {
    logic [BYTE_W-1:0] sym;
    logic [LEN_W-1:0]  len;
    logic              last;
  } run_t;

  typedef struct packed {
    logic [3:0]       d;
    logic [LEN_W:0]   sub;
  } digit_t;

  // Power of ten for a digit position, position 0 being the units.
  function automatic logic [LEN_W:0] pow10(input logic [POS_W-1:0] pos);
    logic [LEN_W:0] p;
    case (pos)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

  // Position of the leading decimal digit of a nonzero length.
  function automatic logic [POS_W-1:0] top_pos(input logic [LEN_W-1:0] len);
    logic [POS_W-1:0] p;
    if (len >= 16'd10000) begin
      p = 3'd4;
    end else if (len >= 16'd1000) begin
      p = 3'd3;
    end else if (len >= 16'd100) begin
      p = 3'd2;
    end else if (len >= 16'd10) begin
      p = 3'd1;
    end else begin
      p = 3'd0;
    end
    return p;
  endfunction

  // Digit at a position of a remainder known to be below ten times that power,
  // together with the amount to take off the remainder.
  function automatic digit_t digit_at(input logic [LEN_W-1:0] rem,
                                      input logic [POS_W-1:0] pos);
    digit_t         r;
    logic [LEN_W:0] pw;
    logic [LEN_W:0] thr;
    r.d   = '0;
    r.sub = '0;
    pw    = pow10(pos);
    for (int k = 1; k <= 9; k++) begin
      thr = (LEN_W+1)'(k) * pw;
      if ({1'b0, rem} >= thr) begin
        r.d   = 4'(k);
        r.sub = thr;
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/run_length_encoder_decimal.sv
// Run-length encoder with decimal counts: top level joining tracker and emitter.
// Depends on rled_pkg, rled_tracker and rled_emitter.
//
// One byte is taken per transfer and a closed run is written out as its byte
// followed by its length in ASCII decimal, most significant digit first, the
// final digit of a string marked by out_last. Runs longer than MAX_RUN split.
// The input side takes one byte per cycle while the two-entry run queue will be
// empty after that cycle; the output side gives one encoded byte per cycle while
// code_stall is low, and a closed run of length L is written as 1 + (number of
// digits of L) bytes, two to six. Further input bytes therefore wait until the
// emitter has taken the queued runs, which sets the sustained input rate to
// the output byte count of the data. An accepted byte that closes a run is held
// in the run queue and then in the output register before its symbol appears.
module run_length_encoder_decimal #(
  parameter int MAX_RUN = rled_pkg::MAX_RUN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  logic [rled_pkg::BYTE_W-1:0] in_byte,
  input  logic                        end_of_string,
  output logic                        code_valid,
  input  logic                        code_stall,
  output logic [rled_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last
);

  rled_pkg::run_t head;
  logic           head_valid;
  logic           pop;

  rled_tracker #(
    .MAX_RUN(MAX_RUN)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop)
  );

  rled_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .code_valid(code_valid),
    .code_stall(code_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

FILE: sv/rled_tracker.sv
// Run tracker: keeps the open run and closes runs into a two-entry queue.
// Depends on rled_pkg.
module rled_tracker #(
  parameter int MAX_RUN = rled_pkg::MAX_RUN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  logic [rled_pkg::BYTE_W-1:0] in_byte,
  input  logic                        end_of_string,
  output rled_pkg::run_t              head,
  output logic                        head_valid,
  input  logic                        pop
);

  logic [rled_pkg::BYTE_W-1:0] run_symbol;
  logic [rled_pkg::LEN_W-1:0]  run_length;
  logic                        run_open;

  rled_pkg::run_t q0, q1;
  logic           q0_valid, q1_valid;

  logic                       accept;
  logic                       close_a, close_b, same;
  logic [rled_pkg::LEN_W-1:0] new_len;
  rled_pkg::run_t             run_a, run_b;

  // New bytes are taken only when the queue will be empty after this cycle.
  assign byte_stall = q1_valid || (q0_valid && !pop);
  assign accept     = byte_valid && !byte_stall;

  assign head       = q0;
  assign head_valid = q0_valid;

  always_comb begin
    same    = run_open && (in_byte == run_symbol);
    close_a = run_open && !same;
    new_len = same ? run_length + 1'b1 : rled_pkg::LEN_W'(1);
    close_b = (new_len >= rled_pkg::LEN_W'(MAX_RUN)) || end_of_string;
    run_a.sym  = run_symbol;
    run_a.len  = run_length;
    run_a.last = 1'b0;
    run_b.sym  = in_byte;
    run_b.len  = new_len;
    run_b.last = end_of_string;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open <= 1'b0;
      q0_valid <= 1'b0;
      q1_valid <= 1'b0;
    end else if (accept) begin
      run_open <= !close_b;
      q0_valid <= close_a || close_b;
      q1_valid <= close_a && close_b;
    end else if (pop) begin
      q0_valid <= q1_valid;
      q1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_symbol <= '0;
      run_length <= '0;
    end else if (accept) begin
      run_symbol <= in_byte;
      run_length <= close_b ? '0 : new_len;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q0 <= close_a ? run_a : run_b;
      q1 <= run_b;
    end else if (pop) begin
      q0 <= q1;
    end
  end

endmodule

FILE: sv/rled_emitter.sv
// Emitter: writes one closed run out as its symbol and then its decimal digits,
// one byte per transfer, through the output register. Depends on rled_pkg.
module rled_emitter (
  input  logic                        clk,
  input  logic                        rst,
  input  rled_pkg::run_t              head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        code_valid,
  input  logic                        code_stall,
  output logic [rled_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last
);

  logic                        busy;
  logic [rled_pkg::LEN_W-1:0]  rem;
  logic [rled_pkg::POS_W-1:0]  pos;
  logic                        last;
  logic                        advance;
  rled_pkg::digit_t            dg;

  // The output register can take a new byte when empty or when its byte leaves.
  assign advance = !code_valid || !code_stall;
  assign pop     = advance && !busy && head_valid;
  assign dg      = rled_pkg::digit_at(rem, pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      code_valid <= 1'b0;
    end else if (advance) begin
      code_valid <= busy || head_valid;
      if (busy) begin
        busy <= (pos != '0);
      end else if (head_valid) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (busy) begin
        out_byte <= rled_pkg::ASCII_ZERO + {4'b0000, dg.d};
        out_last <= last && (pos == '0);
        rem      <= rem - dg.sub[rled_pkg::LEN_W-1:0];
        pos      <= pos - 1'b1;
      end else if (head_valid) begin
        out_byte <= head.sym;
        out_last <= 1'b0;
        rem      <= head.len;
        pos      <= rled_pkg::top_pos(head.len);
        last     <= head.last;
      end
    end
  end

endmodule

FILE: sv/rled_checker.sv
// Port-level checks for the run-length encoder, bound to its top level.
// Depends on run_length_encoder_decimal and rled_pkg.
module rled_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        byte_valid,
  input logic                        byte_stall,
  input logic [rled_pkg::BYTE_W-1:0] in_byte,
  input logic                        end_of_string,
  input logic                        code_valid,
  input logic                        code_stall,
  input logic [rled_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_last
);

  // Nothing is offered on the output right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !code_valid)
    else $error("output valid right after reset");

  // A stalled output byte holds until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> code_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output changed");

  // The byte that ends a string is always a decimal digit of a count.
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    code_valid && out_last |-> out_byte >= 8'h30 && out_byte <= 8'h39)
    else $error("string end flagged on a non-digit byte");

  // After the final digit of a string transfers, the next output byte does not also end a string.
  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_stall && out_last |=> !(code_valid && out_last))
    else $error("two string ends in consecutive transfers");

endmodule

bind run_length_encoder_decimal rled_checker u_rled_checker (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for run_length_encoder_decimal.
// Depends on rled_pkg and the encoder RTL; a scoreboard class predicts the
// encoded byte stream and checks every code transfer against it.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT       = rled_pkg::MAX_RUN_DEF;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } code_t;

  // Predicts the encoded stream from accepted bytes and checks each code byte.
  class rle_scoreboard;
    logic [7:0]  run_sym;
    int unsigned run_len;
    bit          run_open;
    code_t       pending_codes[$];
    int          errors;
    int          checked;
    int          strings;

    function new();
      run_sym  = '0;
      run_len  = 0;
      run_open = 1'b0;
      errors   = 0;
      checked  = 0;
      strings  = 0;
    endfunction

    function void push_code(logic [7:0] code, logic last);
      code_t c;
      c.code = code;
      c.last = last;
      pending_codes.push_back(c);
    endfunction

    // The run byte goes out first, then the length in decimal, leading digit first.
    function void close_run(bit last);
      int unsigned v;
      logic [7:0]  digits[$];
      push_code(run_sym, 1'b0);
      v = run_len;
      do begin
        digits.push_front(8'(DIGIT_ZERO + v % 10));
        v = v / 10;
      end while (v != 0);
      foreach (digits[i]) push_code(digits[i], last && (i == digits.size() - 1));
      run_open = 1'b0;
      run_len  = 0;
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      if (run_open && b != run_sym) close_run(1'b0);
      if (run_open) begin
        run_len++;
      end else begin
        run_sym  = b;
        run_len  = 1;
        run_open = 1'b1;
      end
      if (run_len >= RUN_LIMIT || eos) close_run(eos);
      if (eos) strings++;
    endfunction

    function void check_code(logic [7:0] b, logic last);
      code_t e;
      if (pending_codes.size() == 0) begin
        errors++;
        $error("unexpected code transfer: out_byte 0x%02h out_last %0b", b, last);
        return;
      end
      e = pending_codes.pop_front();
      checked++;
      if (b !== e.code) begin
        errors++;
        $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", e.code, b);
      end
      if (last !== e.last) begin
        errors++;
        $error("out_last mismatch: expected %0b, actual %0b", e.last, last);
      end
    endfunction

    function int pending_count();
      return pending_codes.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid;
  logic       byte_stall;
  logic [7:0] in_byte;
  logic       end_of_string;
  logic       code_valid;
  logic       code_stall;
  logic [7:0] out_byte;
  logic       out_last;

  rle_scoreboard sb = new();

  bit sender_idle_on;
  bit stall_on;
  bit hold_off_req;
  int bytes_sent;

  always #5 clk = ~clk;

  run_length_encoder_decimal #(
    .MAX_RUN(RUN_LIMIT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) sb.note_byte(in_byte, end_of_string);
      if (code_valid && !code_stall) sb.check_code(out_byte, out_last);
    end
  end

  // Receiver: random stall bursts, and one long hold-off when asked for.
  initial begin : receiver
    code_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        code_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        code_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        code_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      byte_valid    <= 1'b0;
      in_byte       <= 8'($urandom);
      end_of_string <= 1'($urandom);
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    byte_valid    <= 1'b1;
    in_byte       <= b;
    end_of_string <= eos;
    do @(posedge clk); while (byte_stall !== 1'b0);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(input logic [7:0] b, input int len, input bit eos);
    for (int i = 0; i < len; i++) send_byte(b, eos && (i == len - 1));
  endtask

  // Holds the input idle until every predicted code byte has been seen.
  task automatic drain();
    byte_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic int pick_run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 12);
    if (r < 98) return $urandom_range(13, 40);
    return $urandom_range(95, 130);
  endfunction

  // Mostly well-formed strings of runs with random bytes, plus loose noise bytes.
  task automatic random_strings(input int count);
    int target;
    int nruns;
    logic [7:0] sym;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        nruns = $urandom_range(1, 6);
        for (int r = 0; r < nruns; r++) begin
          sym = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h30, 8'h39))
                                            : 8'($urandom);
          send_run(sym, pick_run_len(), r == nruns - 1);
        end
      end
    end
  endtask

  initial begin : stimulus
    byte_valid     = 1'b0;
    in_byte        = '0;
    end_of_string  = 1'b0;
    sender_idle_on = 1'b1;
    stall_on       = 1'b1;
    hold_off_req   = 1'b0;
    bytes_sent     = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Byte extremes as one-byte strings, a run closed by a differing byte on
    // the final byte, a two-digit count and runs of ASCII digit bytes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_run(8'h41, 2, 1'b0);
    send_byte(8'h42, 1'b1);
    send_run(8'hAA, 12, 1'b1);
    send_run(8'h30, 3, 1'b0);
    send_byte(8'h31, 1'b1);
    drain();

    // A run of exactly one hundred bytes gives a three-digit count with zeros.
    sender_idle_on = 1'b0;
    send_run(8'h7E, 100, 1'b1);
    sender_idle_on = 1'b1;
    drain();

    random_strings(110);

    // The receiver holds off while alternating bytes keep closing runs, so
    // the encoder backs up into its input.
    sender_idle_on = 1'b0;
    hold_off_req   = 1'b1;
    for (int i = 0; i < 60; i++) send_byte(i[0] ? 8'h5A : 8'hA5, i == 59);
    sender_idle_on = 1'b1;
    drain();

    random_strings(70);

    stall_on       = 1'b0;
    sender_idle_on = 1'b0;
    random_strings(30);
    drain();

    $display("Checked %0d code bytes from %0d input bytes in %0d strings, run limit %0d.",
             sb.checked, bytes_sent, sb.strings, RUN_LIMIT);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Ends the run as a failure if the stimulus has not finished first.
  initial begin : watchdog
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
